// ----- rtl/tmpc_pkg.sv -----
// package: widths, types and helpers for the triangle max path count unit
`default_nettype none
package tmpc_pkg;

  localparam int MAX_ROWS = 128;
  localparam int CELL_W   = 20;
  localparam int SUM_W    = 27;
  localparam int CNT_W    = 32;
  localparam int CFG_W    = 8;
  localparam int ROWS_W   = $clog2(MAX_ROWS + 1);
  localparam int POS_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ROWS_W-1:0] rows_t;
  typedef logic [POS_W-1:0]  pos_t;

  typedef struct packed {
    sum_t best;
    cnt_t cnt;
  } entry_t;

  // per-item control carried from the read stage to the update stage
  typedef struct packed {
    cell_t value;
    pos_t  col;
    logic  row0;
    logic  have_left;
    logic  have_above;
    logic  last_row;
    logic  col0;
    logic  emit;
  } stage_t;

  // saturating count add, msb of the result flags a clamp
  function automatic logic [CNT_W:0] sat_add(input cnt_t a, input cnt_t b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[CNT_W]) begin
      sat_add = {1'b1, {CNT_W{1'b1}}};
    end else begin
      sat_add = s;
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tmpc_in_if.sv -----
// interface: input channel carrying one triangle cell per item
`default_nettype none
interface tmpc_in_if;
  logic            valid;
  logic            ready;
  tmpc_pkg::cell_t cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink (input valid, input cell_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/tmpc_out_if.sv -----
// interface: result channel carrying max sum and path count per triangle
`default_nettype none
interface tmpc_out_if;
  logic           valid;
  logic           ready;
  tmpc_pkg::sum_t max_sum;
  tmpc_pkg::cnt_t path_count;
  logic           count_saturated;

  modport source (output valid, output max_sum, output path_count,
                  output count_saturated, input ready);
  modport sink (input valid, input max_sum, input path_count,
                input count_saturated, output ready);
endinterface
`default_nettype wire

// ----- rtl/triangle_max_path_count_unit.sv -----
// top level: triangle maximum path sum with count of maximal paths
//
// in_chan takes the cells of a triangle row by row, top first, left to
// right; row r holds r+1 cells and cfg_wdata sets the rows per triangle
// (0 acts as 1, values above MAX_ROWS act as MAX_ROWS). After the last
// cell of a triangle one item leaves on out_chan with the largest path
// sum, the number of paths that reach it (saturated at all ones) and a
// saturation flag.
// One cell is accepted per cycle unless in_chan stalls. Each cell reads
// its column from a row memory at acceptance, is combined and written
// back as it leaves the update stage; a same-column hazard is covered
// by forwarding. The result item is registered as its last cell leaves.
// The output register parts the two sides: in_chan stalls only when a
// result is waiting in it, out_chan is not ready and the next cell to
// retire is itself the last cell of a triangle.
// Reset sets rows to 1 and clears positions and running values; the
// row memory needs no clearing since every entry is written before it
// is read. A configuration write also restarts the current triangle.
`default_nettype none
module triangle_max_path_count_unit (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       cfg_we,
  input  wire [tmpc_pkg::CFG_W-1:0] cfg_wdata,
  tmpc_in_if.sink                   in_chan,
  tmpc_out_if.source                out_chan
);

  tmpc_pkg::entry_t mem [tmpc_pkg::MAX_ROWS];

  tmpc_pkg::rows_t  rows_r;
  tmpc_pkg::pos_t   row_r, col_r;
  tmpc_pkg::stage_t s1_r;
  logic             s1_valid_r;
  tmpc_pkg::entry_t rd_r, fwd_data_r;
  logic             fwd_hit_r;
  tmpc_pkg::entry_t held_r;
  tmpc_pkg::sum_t   run_max_r;
  tmpc_pkg::cnt_t   run_cnt_r;
  logic             ovf_r;
  logic             out_valid_r;
  tmpc_pkg::sum_t   out_sum_r;
  tmpc_pkg::cnt_t   out_cnt_r;
  logic             out_sat_r;

  logic             in_ready, accept, out_free, s1_go;
  logic             last_col, emit0;
  tmpc_pkg::rows_t  row_inc;
  tmpc_pkg::entry_t above, wr_entry;
  logic [tmpc_pkg::CNT_W:0] tie_sum, run_sum;
  tmpc_pkg::sum_t   run_max_nxt;
  tmpc_pkg::cnt_t   run_cnt_nxt;
  logic             ovf_nxt;

  // read stage
  assign out_free = !out_valid_r || out_chan.ready;
  assign s1_go    = s1_valid_r && (!s1_r.emit || out_free);
  assign in_ready = !s1_valid_r || s1_go;
  assign accept   = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;

  assign last_col = (col_r == row_r);
  assign row_inc  = tmpc_pkg::ROWS_W'(row_r) + tmpc_pkg::ROWS_W'(1);
  assign emit0    = last_col && (row_inc >= rows_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= tmpc_pkg::ROWS_W'(1);
      row_r <= '0;
      col_r <= '0;
      s1_valid_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_wdata == '0) begin
        rows_r <= tmpc_pkg::ROWS_W'(1);
      end else if (int'(cfg_wdata) > tmpc_pkg::MAX_ROWS) begin
        rows_r <= tmpc_pkg::ROWS_W'(tmpc_pkg::MAX_ROWS);
      end else begin
        rows_r <= tmpc_pkg::ROWS_W'(cfg_wdata);
      end
      row_r <= '0;
      col_r <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
        priority if (emit0) begin
          row_r <= '0;
          col_r <= '0;
        end else if (last_col) begin
          row_r <= row_r + tmpc_pkg::POS_W'(1);
          col_r <= '0;
        end else begin
          col_r <= col_r + tmpc_pkg::POS_W'(1);
        end
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= mem[col_r];
      fwd_hit_r <= s1_go && (s1_r.col == col_r);
      fwd_data_r <= wr_entry;
      s1_r.value <= in_chan.cell_value;
      s1_r.col <= col_r;
      s1_r.row0 <= (row_r == '0);
      s1_r.have_left <= (col_r != '0);
      s1_r.have_above <= !last_col;
      s1_r.last_row <= (row_inc == rows_r);
      s1_r.col0 <= (col_r == '0);
      s1_r.emit <= emit0;
    end
    if (s1_go) begin
      mem[s1_r.col] <= wr_entry;
    end
  end

  // update stage
  assign above = fwd_hit_r ? fwd_data_r : rd_r;

  always_comb begin
    wr_entry = '0;
    tie_sum = '0;
    run_sum = '0;
    ovf_nxt = ovf_r;
    run_max_nxt = run_max_r;
    run_cnt_nxt = run_cnt_r;
    priority if (s1_r.row0) begin
      wr_entry.best = tmpc_pkg::SUM_W'(s1_r.value);
      wr_entry.cnt = tmpc_pkg::CNT_W'(1);
    end else if (s1_r.have_left && s1_r.have_above) begin
      priority if (held_r.best > above.best) begin
        wr_entry = held_r;
      end else if (above.best > held_r.best) begin
        wr_entry = above;
      end else begin
        tie_sum = tmpc_pkg::sat_add(held_r.cnt, above.cnt);
        wr_entry.best = above.best;
        wr_entry.cnt = tie_sum[tmpc_pkg::CNT_W-1:0];
        ovf_nxt = ovf_nxt | tie_sum[tmpc_pkg::CNT_W];
      end
      wr_entry.best = wr_entry.best + tmpc_pkg::SUM_W'(s1_r.value);
    end else if (s1_r.have_left) begin
      wr_entry.best = held_r.best + tmpc_pkg::SUM_W'(s1_r.value);
      wr_entry.cnt = held_r.cnt;
    end else begin
      wr_entry.best = above.best + tmpc_pkg::SUM_W'(s1_r.value);
      wr_entry.cnt = above.cnt;
    end
    if (s1_r.last_row) begin
      priority if (s1_r.col0 || wr_entry.best > run_max_r) begin
        run_max_nxt = wr_entry.best;
        run_cnt_nxt = wr_entry.cnt;
      end else if (wr_entry.best == run_max_r) begin
        run_sum = tmpc_pkg::sat_add(run_cnt_r, wr_entry.cnt);
        run_cnt_nxt = run_sum[tmpc_pkg::CNT_W-1:0];
        ovf_nxt = ovf_nxt | run_sum[tmpc_pkg::CNT_W];
      end else begin
        run_cnt_nxt = run_cnt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      held_r <= '0;
      run_max_r <= '0;
      run_cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (s1_go) begin
      held_r <= s1_r.have_above ? above : '0;
      if (s1_r.emit) begin
        run_max_r <= '0;
        run_cnt_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        run_max_r <= run_max_nxt;
        run_cnt_r <= run_cnt_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_r.emit) begin
      out_sum_r <= run_max_nxt;
      out_cnt_r <= run_cnt_nxt;
      out_sat_r <= ovf_nxt && (&run_cnt_nxt);
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.max_sum = out_sum_r;
  assign out_chan.path_count = out_cnt_r;
  assign out_chan.count_saturated = out_sat_r;

  a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_r.emit |=> out_valid_r)
    else $error("finished triangle did not reach the result register");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && s1_r.emit && out_valid_r)
    else $error("input stalled without a waiting result");

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= row_r)
    else $error("column position beyond its row");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    tmpc_pkg::ROWS_W'(row_r) < rows_r)
    else $error("row position beyond the triangle");

  a_sat_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sat_r |-> (&out_cnt_r))
    else $error("saturation flag with a count below all ones");

endmodule
`default_nettype wire
